[rtl/sexpr_token_scanner_defines.svh]
// ----------------------------------------------------------------------------
// sexpr_token_scanner assertion macros
// Concurrent assertion shorthands, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_SCANNER_DEFINES_SVH
`define SEXPR_TOKEN_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define STS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define STS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define STS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Types, character codes and helpers shared by the s-expression scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  parameter int MAX_WORD_DEF = 128;
  parameter int FIFO_DEPTH   = 4;
  localparam int FifoPtrW    = $clog2(FIFO_DEPTH);
  localparam int FifoCntW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [6:0] KW_LEN = 7'd5;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_OPEN     = 3'd0,
    KIND_CLOSE    = 3'd1,
    KIND_QUOTE    = 3'd2,
    KIND_NEWLINE  = 3'd3,
    KIND_EOF      = 3'd4,
    KIND_WORDCHAR = 3'd5,
    KIND_WORDEND  = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_BARE    = 4'b0100,
    MODE_QUOTED  = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    logic [6:0] word_length;
    logic       quote_keyword;
    logic       too_long;
    logic       last;
  } result_t;

  // Up to two results per request, in order.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic                room;
    logic                empty;
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h71;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] word_cap(int max_word);
    int cap;
    cap = (max_word - 1 < 127) ? max_word - 1 : 127;
    return 7'(cap);
  endfunction

endpackage

[rtl/sts_scan_core.sv]
// ----------------------------------------------------------------------------
// sts_scan_core
// Scan mode and word state, and the token results of one registered request.
// ----------------------------------------------------------------------------
module sts_scan_core #(
  parameter int MAX_WORD = sts_pkg::MAX_WORD_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    ch_i,
  input  logic          eof_i,
  output sts_pkg::push_t push_o
);
  import sts_pkg::*;

  localparam logic [6:0] WordCap = word_cap(MAX_WORD);

  mode_e      mode_q, mode_d;
  logic [6:0] cnt_q, cnt_d;
  logic       kw_q, kw_d;
  logic       ovf_q, ovf_d;

  logic       is_ws, is_cmt, is_delim, is_nl_cr;
  logic       flush, bare, run_between, take, start;
  logic       vb;
  result_t    rb, rend;
  logic [6:0] base_cnt;
  logic       base_kw, base_ovf;

  assign is_ws    = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_CR);
  assign is_cmt   = (ch_i == CH_HASH) || (ch_i == CH_SEMI);
  assign is_nl_cr = eof_i || (ch_i == CH_LF) || (ch_i == CH_CR);
  assign is_delim = is_nl_cr || is_cmt || (ch_i == CH_OPEN) || (ch_i == CH_CLOSE)
                    || (ch_i == CH_SPACE);

  always_comb begin
    flush       = 1'b0;
    bare        = 1'b0;
    run_between = 1'b0;
    take        = 1'b0;
    start       = 1'b0;
    mode_d      = mode_q;
    vb          = 1'b0;
    rb          = '0;
    rb.kind     = KIND_OPEN;

    unique case (mode_q)
      MODE_BETWEEN: run_between = 1'b1;
      MODE_COMMENT: run_between = eof_i || (ch_i == CH_LF);
      MODE_BARE: begin
        if (is_delim) begin
          flush       = 1'b1;
          bare        = 1'b1;
          run_between = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (is_nl_cr) begin
          flush       = 1'b1;
          run_between = 1'b1;
        end else if (ch_i == CH_DQUOT) begin
          flush = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: run_between = 1'b1;
    endcase

    if (flush) begin
      mode_d = MODE_BETWEEN;
    end

    if (run_between) begin
      mode_d = MODE_BETWEEN;
      if (eof_i) begin
        vb      = 1'b1;
        rb.kind = KIND_EOF;
      end else if (is_ws) begin
        vb = 1'b0;
      end else if (is_cmt) begin
        mode_d = MODE_COMMENT;
      end else if (ch_i == CH_OPEN) begin
        vb      = 1'b1;
        rb.kind = KIND_OPEN;
      end else if (ch_i == CH_CLOSE) begin
        vb      = 1'b1;
        rb.kind = KIND_CLOSE;
      end else if (ch_i == CH_APOS) begin
        vb      = 1'b1;
        rb.kind = KIND_QUOTE;
      end else if (ch_i == CH_LF) begin
        vb      = 1'b1;
        rb.kind = KIND_NEWLINE;
      end else if (ch_i == CH_DQUOT) begin
        mode_d = MODE_QUOTED;
        start  = 1'b1;
      end else begin
        mode_d = MODE_BARE;
        start  = 1'b1;
        take   = 1'b1;
      end
    end

    if (take) begin
      vb          = 1'b1;
      rb.kind     = KIND_WORDCHAR;
      rb.out_char = ch_i;
    end
  end

  // A word end or a fresh word restarts the counters.
  always_comb begin
    base_cnt = (flush || start) ? 7'd0 : cnt_q;
    base_kw  = (flush || start) ? 1'b1 : kw_q;
    base_ovf = (flush || start) ? 1'b0 : ovf_q;
    cnt_d    = base_cnt;
    kw_d     = base_kw;
    ovf_d    = base_ovf;
    if (take) begin
      kw_d = base_kw && (base_cnt < KW_LEN) && (ch_i == kw_char(base_cnt[2:0]));
      if (base_cnt >= WordCap) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = base_cnt + 7'd1;
      end
    end
  end

  always_comb begin
    rend               = '0;
    rend.kind          = KIND_WORDEND;
    rend.word_length   = cnt_q;
    rend.too_long      = ovf_q;
    rend.quote_keyword = bare && kw_q && !ovf_q && (cnt_q == KW_LEN);

    push_o = '0;
    if (fire_i) begin
      if (flush) begin
        push_o.r0      = rend;
        push_o.r0.last = !vb;
        push_o.r1      = rb;
        push_o.r1.last = 1'b1;
        push_o.n       = vb ? 2'd2 : 2'd1;
      end else if (vb) begin
        push_o.r0      = rb;
        push_o.r0.last = 1'b1;
        push_o.n       = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
      cnt_q  <= 7'd0;
      kw_q   <= 1'b1;
      ovf_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      kw_q   <= kw_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

[rtl/sts_out_fifo.sv]
// ----------------------------------------------------------------------------
// sts_out_fifo
// Small result queue: takes up to two results a cycle, gives one a cycle while it is popped.
// ----------------------------------------------------------------------------
module sts_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sts_pkg::push_t        push_i,
  input  logic                  pop_i,
  output sts_pkg::result_t      head_o,
  output sts_pkg::fifo_status_t status_o
);
  import sts_pkg::*;

  result_t             mem_q [FIFO_DEPTH];
  logic [FifoPtrW-1:0] head_q, head_d, tail_q, tail_d, tail_p1;
  logic [FifoCntW-1:0] count_q, count_d;

  assign tail_p1 = tail_q + FifoPtrW'(1);
  assign head_o  = mem_q[head_q];

  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  // Leave space for a two-result request, counting the head leaving now.
  assign status_o.room  = (count_q - FifoCntW'(pop_i)) <= FifoCntW'(FIFO_DEPTH - 2);

  always_comb begin
    head_d  = pop_i ? head_q + FifoPtrW'(1) : head_q;
    tail_d  = tail_q + FifoPtrW'(push_i.n);
    count_d = count_q + FifoCntW'(push_i.n) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[tail_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/sexpr_token_scanner.sv]
// A request passes through the input register and then the result queue before its
// first result is on the output. The scanner takes one request per cycle while
// in_stall_o is low; a request that yields two results (word end followed by a
// delimiter token) gives them on the output one after the other, as the result
// queue reads out one result at a time. Reset (rst_ni low, asynchronous) clears the
// scan mode to between tokens, the word state and both pipeline valids.
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// Byte-stream lexer for s-expressions: input register, scan core, result queue.
// ----------------------------------------------------------------------------
`include "sexpr_token_scanner_defines.svh"

module sexpr_token_scanner #(
  parameter int MAX_WORD = sts_pkg::MAX_WORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_char_o,
  output logic [6:0] word_length_o,
  output logic       quote_keyword_o,
  output logic       too_long_o,
  output logic       last_o
);
  import sts_pkg::*;

  localparam logic [6:0] WordCap = word_cap(MAX_WORD);

  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   s1_ch_q;
  logic         s1_eof_q;
  logic         fire, pop;
  push_t        push;
  result_t      head;
  fifo_status_t fstat;

  assign pop        = out_valid_o && !out_stall_i;
  assign fire       = s1_valid_q && fstat.room;
  assign in_stall_o = s1_valid_q && !fstat.room;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Hold the registered byte while stalled.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_ch_q  <= ch_i;
      s1_eof_q <= end_of_file_i;
    end
  end

  sts_scan_core #(
    .MAX_WORD(MAX_WORD)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .ch_i  (s1_ch_q),
    .eof_i (s1_eof_q),
    .push_o(push)
  );

  sts_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(fstat)
  );

  assign out_valid_o     = !fstat.empty;
  assign kind_o          = head.kind;
  assign out_char_o      = head.out_char;
  assign word_length_o   = head.word_length;
  assign quote_keyword_o = head.quote_keyword;
  assign too_long_o      = head.too_long;
  assign last_o          = head.last;

  `STS_ASSERT_IMPL(a_fifo_bound, clk_i, rst_ni, 1'b1,
    fstat.count <= FifoCntW'(FIFO_DEPTH), "result queue over capacity")
  `STS_ASSERT_IMPL(a_keyword_len, clk_i, rst_ni, out_valid_o && quote_keyword_o,
    (kind_o == KIND_WORDEND) && (word_length_o == KW_LEN) && !too_long_o,
    "keyword flag on a result that is not a five-character word end")
  `STS_ASSERT_IMPL(a_too_long_sat, clk_i, rst_ni, out_valid_o && too_long_o,
    word_length_o == WordCap, "too-long word length not saturated")
  `STS_ASSERT_NEXT(a_push_room, clk_i, rst_ni, fire && (push.n == 2'd2),
    fstat.count != '0, "two-result request lost in the result queue")

endmodule

[tb/sexpr_token_scanner_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sexpr_token_scanner_tb
// Streams directed and random s-expression text into the scanner with bursty
// input and a stalling output, predicts tokens in a local scanner model or takes
// them from typed rows, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_tb;
  import sts_pkg::*;

  localparam int WORD_CAP = (MAX_WORD_DEF - 1 < 127) ? MAX_WORD_DEF - 1 : 127;
  localparam int RANDOM_ITEMS = 900;
  localparam int PRESSURE_CYCLES = 120;
  localparam logic [7:0] KEYWORD [5] = '{"q", "u", "o", "t", "e"};

  typedef struct {
    logic [7:0] ch;
    logic       eof;
    int         n_typed;   // -1: take the prediction
    result_t    t0;
    result_t    t1;
  } text_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ch_i;
  logic       end_of_file_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] out_char_o;
  logic [6:0] word_length_o;
  logic       quote_keyword_o;
  logic       too_long_o;
  logic       last_o;

  sexpr_token_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .ch_i            (ch_i),
    .end_of_file_i   (end_of_file_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_char_o      (out_char_o),
    .word_length_o   (word_length_o),
    .quote_keyword_o (quote_keyword_o),
    .too_long_o      (too_long_o),
    .last_o          (last_o)
  );

  // Scanner state mirror
  mode_e      scan_mode;
  logic [6:0] word_len;
  logic       kw_match;
  logic       word_over;
  result_t    lex_out [2];
  int         lex_n;

  text_item_t text_q [$];
  result_t    token_expect [$];
  int         useful_items;
  int         items_sent;
  int         err_count;
  int         tokens_checked;
  int         words_ended;
  int         keywords_seen;
  int         long_words_seen;
  int         in_stall_cycles;
  bit         pressure_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic result_t res(kind_e k, logic [7:0] c, logic [6:0] len, logic kw,
                                  logic tl, logic lst);
    result_t r;
    r.kind          = k;
    r.out_char      = c;
    r.word_length   = len;
    r.quote_keyword = kw;
    r.too_long      = tl;
    r.last          = lst;
    return r;
  endfunction

  function automatic void emit_tok(kind_e k, logic [7:0] c, logic [6:0] len, logic kw,
                                   logic tl);
    lex_out[lex_n] = res(k, c, len, kw, tl, 1'b0);
    lex_n++;
  endfunction

  function automatic void word_begin(mode_e m);
    scan_mode = m;
    word_len  = '0;
    kw_match  = 1'b1;
    word_over = 1'b0;
  endfunction

  function automatic void word_take(logic [7:0] c);
    if (word_len >= 5) kw_match = 1'b0;
    else if (c != KEYWORD[word_len]) kw_match = 1'b0;
    if (word_len >= WORD_CAP) word_over = 1'b1;
    else word_len++;
  endfunction

  function automatic void word_finish(logic bare);
    logic kw;
    kw = bare && kw_match && !word_over && (word_len == 7'd5);
    emit_tok(KIND_WORDEND, 8'h00, word_len, kw, word_over);
    word_begin(MODE_BETWEEN);
  endfunction

  function automatic void between_tok(logic [7:0] c, logic e);
    if (e) begin
      emit_tok(KIND_EOF, 8'h00, 7'd0, 1'b0, 1'b0);
    end else begin
      case (c)
        CH_SPACE, CH_TAB, CH_CR: ;
        CH_HASH, CH_SEMI: scan_mode = MODE_COMMENT;
        CH_OPEN:  emit_tok(KIND_OPEN, 8'h00, 7'd0, 1'b0, 1'b0);
        CH_CLOSE: emit_tok(KIND_CLOSE, 8'h00, 7'd0, 1'b0, 1'b0);
        CH_APOS:  emit_tok(KIND_QUOTE, 8'h00, 7'd0, 1'b0, 1'b0);
        CH_LF:    emit_tok(KIND_NEWLINE, 8'h00, 7'd0, 1'b0, 1'b0);
        CH_DQUOT: word_begin(MODE_QUOTED);
        default: begin
          word_begin(MODE_BARE);
          word_take(c);
          emit_tok(KIND_WORDCHAR, c, 7'd0, 1'b0, 1'b0);
        end
      endcase
    end
  endfunction

  // Advance the mirror by one request; tokens land in lex_out[0 .. lex_n-1].
  function automatic void scan_byte(logic [7:0] c, logic e);
    lex_n = 0;
    case (scan_mode)
      MODE_COMMENT: begin
        if (e || c == CH_LF) begin
          scan_mode = MODE_BETWEEN;
          between_tok(c, e);
        end
      end
      MODE_BARE: begin
        if (e || c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI || c == CH_HASH ||
            c == CH_SPACE || c == CH_LF || c == CH_CR) begin
          word_finish(1'b1);
          between_tok(c, e);
        end else begin
          word_take(c);
          emit_tok(KIND_WORDCHAR, c, 7'd0, 1'b0, 1'b0);
        end
      end
      MODE_QUOTED: begin
        if (e || c == CH_LF || c == CH_CR) begin
          word_finish(1'b0);
          between_tok(c, e);
        end else if (c == CH_DQUOT) begin
          word_finish(1'b0);
        end else begin
          word_take(c);
          emit_tok(KIND_WORDCHAR, c, 7'd0, 1'b0, 1'b0);
        end
      end
      default: between_tok(c, e);
    endcase
    if (lex_n > 0) lex_out[lex_n - 1].last = 1'b1;
  endfunction

  function automatic void add_row(logic [7:0] c, logic e, int n, result_t t0, result_t t1);
    text_item_t it;
    it.ch      = c;
    it.eof     = e;
    it.n_typed = n;
    it.t0      = t0;
    it.t1      = t1;
    text_q.push_back(it);
  endfunction

  function automatic void push_byte(logic [7:0] c, logic e, bit counts);
    add_row(c, e, -1, '0, '0);
    if (counts) useful_items++;
  endfunction

  function automatic bit is_bare_delim(logic [7:0] c);
    return c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI || c == CH_HASH ||
           c == CH_SPACE || c == CH_LF || c == CH_CR;
  endfunction

  // Any byte that continues a bare word.
  function automatic logic [7:0] bare_body_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (is_bare_delim(c));
    return c;
  endfunction

  // A byte that opens a bare word from between tokens.
  function automatic logic [7:0] bare_start_byte();
    logic [7:0] c;
    do c = bare_body_byte(); while (c == CH_TAB || c == CH_APOS || c == CH_DQUOT);
    return c;
  endfunction

  function automatic logic [7:0] quoted_body_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_DQUOT || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic void end_bare_word();
    logic [7:0] delims [7];
    delims = '{CH_OPEN, CH_CLOSE, CH_SEMI, CH_HASH, CH_SPACE, CH_LF, CH_CR};
    if ($urandom_range(0, 7) == 0) push_byte(8'($urandom), 1'b1, 1);
    else push_byte(delims[$urandom_range(0, 6)], 1'b0, 1);
  endfunction

  function automatic void build_random_text();
    int sel;
    int len;
    logic [7:0] c;
    while (useful_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        // bare word, sometimes the keyword or a near miss
        len = $urandom_range(0, 9);
        if (len == 0) begin
          foreach (KEYWORD[k]) push_byte(KEYWORD[k], 1'b0, 1);
        end else if (len == 1) begin
          for (int k = 0; k < 4; k++) push_byte(KEYWORD[k], 1'b0, 1);
          if ($urandom_range(0, 1)) push_byte(bare_body_byte(), 1'b0, 1);
        end else begin
          push_byte(bare_start_byte(), 1'b0, 1);
          for (int k = 1; k < len; k++) push_byte(bare_body_byte(), 1'b0, 1);
        end
        end_bare_word();
      end else if (sel < 32) begin
        // long word around and beyond the length cap
        case ($urandom_range(0, 3))
          0: len = WORD_CAP;
          1: len = WORD_CAP + 1;
          2: len = WORD_CAP - 1;
          default: len = $urandom_range(WORD_CAP + 2, 200);
        endcase
        push_byte(bare_start_byte(), 1'b0, 1);
        for (int k = 1; k < len; k++) push_byte(bare_body_byte(), 1'b0, 1);
        end_bare_word();
      end else if (sel < 50) begin
        // quoted word
        push_byte(CH_DQUOT, 1'b0, 1);
        if ($urandom_range(0, 5) == 0) begin
          foreach (KEYWORD[k]) push_byte(KEYWORD[k], 1'b0, 1);
        end else begin
          len = $urandom_range(0, 8);
          for (int k = 0; k < len; k++) push_byte(quoted_body_byte(), 1'b0, 1);
        end
        case ($urandom_range(0, 7))
          0: push_byte(CH_LF, 1'b0, 1);
          1: push_byte(CH_CR, 1'b0, 1);
          2: push_byte(8'($urandom), 1'b1, 1);
          default: push_byte(CH_DQUOT, 1'b0, 1);
        endcase
      end else if (sel < 58) begin
        // comment, body bytes are dropped
        push_byte($urandom_range(0, 1) ? CH_HASH : CH_SEMI, 1'b0, 0);
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          do c = 8'($urandom); while (c == CH_LF);
          push_byte(c, 1'b0, 0);
        end
        if ($urandom_range(0, 4) == 0) push_byte(8'($urandom), 1'b1, 1);
        else push_byte(CH_LF, 1'b0, 1);
      end else if (sel < 85) begin
        case ($urandom_range(0, 6))
          0: push_byte(CH_OPEN, 1'b0, 1);
          1: push_byte(CH_CLOSE, 1'b0, 1);
          2: push_byte(CH_APOS, 1'b0, 1);
          3: push_byte(CH_LF, 1'b0, 1);
          4: push_byte(CH_SPACE, 1'b0, 0);
          5: push_byte(CH_TAB, 1'b0, 0);
          default: push_byte(CH_CR, 1'b0, 0);
        endcase
      end else begin
        // noise
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          push_byte(8'($urandom), ($urandom_range(0, 9) == 0), 1);
      end
    end
  endfunction

  function automatic void build_directed_text();
    result_t none;
    none = '0;
    add_row(CH_OPEN,  1'b0, 1, res(KIND_OPEN, 0, 0, 0, 0, 1), none);
    add_row(CH_CLOSE, 1'b0, 1, res(KIND_CLOSE, 0, 0, 0, 0, 1), none);
    add_row(CH_APOS,  1'b0, 1, res(KIND_QUOTE, 0, 0, 0, 0, 1), none);
    add_row(CH_LF,    1'b0, 1, res(KIND_NEWLINE, 0, 0, 0, 0, 1), none);
    add_row(CH_SPACE, 1'b0, 0, none, none);
    add_row(CH_TAB,   1'b0, 0, none, none);
    add_row(CH_CR,    1'b0, 0, none, none);
    foreach (KEYWORD[k]) add_row(KEYWORD[k], 1'b0, -1, none, none);
    // keyword closed by a delimiter that has its own token
    add_row(CH_CLOSE, 1'b0, 2, res(KIND_WORDEND, 0, 5, 1, 0, 0),
            res(KIND_CLOSE, 0, 0, 0, 0, 1));
    add_row(CH_SEMI,  1'b0, 0, none, none);
    add_row(8'hFF,    1'b0, 0, none, none);
    // end of file closes a comment
    add_row(8'h00,    1'b1, 1, res(KIND_EOF, 0, 0, 0, 0, 1), none);
    add_row(CH_DQUOT, 1'b0, 0, none, none);
    add_row(CH_DQUOT, 1'b0, 1, res(KIND_WORDEND, 0, 0, 0, 0, 1), none);
    add_row(CH_HASH,  1'b0, 0, none, none);
    add_row(CH_LF,    1'b0, 1, res(KIND_NEWLINE, 0, 0, 0, 0, 1), none);
    add_row(8'hFF,    1'b0, -1, none, none);
    add_row(CH_DQUOT, 1'b0, -1, none, none);
    add_row(CH_TAB,   1'b0, -1, none, none);
    // CR ends the word and is then skipped
    add_row(CH_CR,    1'b0, -1, none, none);
    add_row(8'hFF,    1'b1, 1, res(KIND_EOF, 0, 0, 0, 0, 1), none);
  endfunction

  // Sender: bursts of requests with random gaps.
  initial begin : sender
    int burst_left;
    int gap;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    ch_i          = 8'h00;
    end_of_file_i = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    useful_items  = 0;
    burst_left    = 0;
    word_begin(MODE_BETWEEN);
    build_directed_text();
    build_random_text();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      in_valid_i    <= 1'b1;
      ch_i          <= text_q[i].ch;
      end_of_file_i <= text_q[i].eof;
      do begin
        @(posedge clk_i);
        if (in_stall_o) in_stall_cycles++;
      end while (in_stall_o);
      scan_byte(text_q[i].ch, text_q[i].eof);
      if (text_q[i].n_typed < 0) begin
        for (int k = 0; k < lex_n; k++) token_expect.push_back(lex_out[k]);
      end else begin
        if (text_q[i].n_typed > 0) token_expect.push_back(text_q[i].t0);
        if (text_q[i].n_typed > 1) token_expect.push_back(text_q[i].t1);
      end
      items_sent++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
    while (token_expect.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d tokens: %0d words, %0d keywords, %0d too long.",
             items_sent, tokens_checked, words_ended, keywords_seen, long_words_seen);
    $display("Input held off for %0d cycles under output back-pressure.", in_stall_cycles);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: stall patterns of its own, plus one long hold-off.
  initial begin : receiver
    int pattern;
    int seg_len;
    out_stall_i   = 1'b0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!pressure_done && items_sent > 200) begin
        for (int k = 0; k < PRESSURE_CYCLES; k++) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        pressure_done = 1'b1;
      end
      pattern = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 150);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk_i);
        case (pattern)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ((k % 4) == 3);
        endcase
      end
    end
  end

  // Check every accepted token against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_expect.size() == 0) begin
        $error("unexpected token: kind %0d char %02h", kind_o, out_char_o);
        err_count++;
      end else begin
        want = token_expect.pop_front();
        tokens_checked++;
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          err_count++;
        end
        if (out_char_o !== want.out_char) begin
          $error("out_char: expected %02h, got %02h", want.out_char, out_char_o);
          err_count++;
        end
        if (word_length_o !== want.word_length) begin
          $error("word_length: expected %0d, got %0d", want.word_length, word_length_o);
          err_count++;
        end
        if (quote_keyword_o !== want.quote_keyword) begin
          $error("quote_keyword: expected %0b, got %0b", want.quote_keyword,
                 quote_keyword_o);
          err_count++;
        end
        if (too_long_o !== want.too_long) begin
          $error("too_long: expected %0b, got %0b", want.too_long, too_long_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          err_count++;
        end
        if (want.kind == KIND_WORDEND) words_ended++;
        if (want.quote_keyword) keywords_seen++;
        if (want.too_long) long_words_seen++;
      end
    end
  end

endmodule
